/* rtl/core/pcr_bank_sha1_extend_replay_defines.svh */
// Assertion macros shared by the PCR replay RTL.
`ifndef PCR_BANK_SHA1_EXTEND_REPLAY_DEFINES_SVH
`define PCR_BANK_SHA1_EXTEND_REPLAY_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PCRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PCRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcrx_pkg.sv */
// Constants and widths for the SHA-1 PCR bank replay block.
`default_nettype none

package pcrx_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PCR_W     = 160;
    localparam int unsigned ROUNDS    = 80;
    localparam int unsigned RND_W     = 7;
    localparam int unsigned SCHED_LEN = 16;

    localparam int unsigned S_DATA_W  = 336;
    localparam int unsigned S_USER_W  = 32;
    localparam int unsigned M_DATA_W  = 168;
    localparam int unsigned M_USER_W  = 3;

    // SHA-1 initial chaining value
    localparam logic [WORD_W-1:0] H0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] H1 = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] H2 = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] H3 = 32'h1032_5476;
    localparam logic [WORD_W-1:0] H4 = 32'hC3D2_E1F0;

    // Round constants
    localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

    // Padding of a 40-byte message: marker word and 320-bit length word
    localparam logic [WORD_W-1:0] PAD_MARK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] PAD_LEN  = 32'h0000_0140;

    // Startup locality event
    localparam logic [31:0] NO_ACTION_TYPE     = 32'h0000_0003;
    localparam logic [31:0] LOCALITY_BODY_SIZE = 32'd17;
    localparam logic [63:0] SIG_FRONT          = 64'h5374_6172_7475_704C;
    localparam logic [63:0] SIG_BACK           = 64'h6F63_616C_6974_7900;

    // Result flag positions in the output tuser
    localparam int unsigned FLAG_EXTENDED = 0;
    localparam int unsigned FLAG_LOCALITY = 1;
    localparam int unsigned FLAG_VALID    = 2;

endpackage

`default_nettype wire

/* rtl/core/pcr_bank_sha1_extend_replay.sv */
// Top level: SHA-1 PCR bank that replays measurement-log events one at a time.
//
//  channel   dir  tdata (lowest bit up)                        tuser
//  s_axis    in   pcr_index, body_size, digest_top,            event_type
//                 digest_middle, digest_tail, signature_front,
//                 signature_back, locality_byte (336 bits)
//  m_axis    out  pcr_echo, value_top, value_middle,           extended, locality_applied,
//                 value_tail (168 bits)                        index_valid
//
// An extending event runs one SHA-1 round per cycle in the single round unit through
// every round (S_ROUND), then S_FINISH adds the chaining value and writes the PCR back,
// and S_DELIVER loads the output register. Any other event goes from S_IDLE straight to
// S_FINISH and S_DELIVER. The input side is ready only when no event is in work, so the
// next event can transfer in the cycle after the result is loaded.
// Reset (synchronous, active low) clears every PCR to zero and empties the output.
// A stalled output register holds its result; the next event may then be taken and
// worked on, and waits for delivery until the output register is free.
`default_nettype none
`include "pcr_bank_sha1_extend_replay_defines.svh"

module pcr_bank_sha1_extend_replay #(
    parameter int unsigned PCR_COUNT = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // event input
    input  wire logic                          i_s_axis_tvalid,
    output      logic                          o_s_axis_tready,
    // pcr_index[7:0], body_size[39:8], digest_top[103:40], digest_middle[167:104],
    // digest_tail[199:168], signature_front[263:200], signature_back[327:264],
    // locality_byte[335:328]
    input  wire logic [pcrx_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // event_type[31:0]
    input  wire logic [pcrx_pkg::S_USER_W-1:0] i_s_axis_tuser,
    // result output
    output      logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // pcr_echo[7:0], value_top[71:8], value_middle[135:72], value_tail[167:136]
    output      logic [pcrx_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // extended[0], locality_applied[1], index_valid[2]
    output      logic [pcrx_pkg::M_USER_W-1:0] o_m_axis_tuser
);

    localparam int unsigned IDX_W = (PCR_COUNT > 1) ? $clog2(PCR_COUNT) : 1;
    localparam int unsigned W     = pcrx_pkg::WORD_W;
    localparam logic [pcrx_pkg::RND_W-1:0] LastRound = pcrx_pkg::RND_W'(pcrx_pkg::ROUNDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_FINISH,
        S_DELIVER
    } t_state;

    // Unpack the input fields
    logic [7:0]  w_pcr_index;
    logic [31:0] w_event_type;
    logic [31:0] w_body_size;
    logic [63:0] w_digest_top;
    logic [63:0] w_digest_middle;
    logic [31:0] w_digest_tail;
    logic [63:0] w_sig_front;
    logic [63:0] w_sig_back;
    logic [7:0]  w_locality;

    assign w_pcr_index     = i_s_axis_tdata[7:0];
    assign w_body_size     = i_s_axis_tdata[39:8];
    assign w_digest_top    = i_s_axis_tdata[103:40];
    assign w_digest_middle = i_s_axis_tdata[167:104];
    assign w_digest_tail   = i_s_axis_tdata[199:168];
    assign w_sig_front     = i_s_axis_tdata[263:200];
    assign w_sig_back      = i_s_axis_tdata[327:264];
    assign w_locality      = i_s_axis_tdata[335:328];
    assign w_event_type    = i_s_axis_tuser;

    // State and storage
    t_state                          r_state;
    logic [pcrx_pkg::RND_W-1:0]      r_round;
    logic [pcrx_pkg::PCR_W-1:0]      r_pcr [PCR_COUNT];
    logic [W-1:0]                    r_w [pcrx_pkg::SCHED_LEN];
    logic [W-1:0]                    r_a, r_b, r_c, r_d, r_e;
    logic [pcrx_pkg::PCR_W-1:0]      r_old;      // PCR before the event, then after it
    logic [7:0]                      r_idx;
    logic [7:0]                      r_locb;
    logic                            r_ext;
    logic                            r_loc;
    logic                            r_valid;
    logic                            r_m_valid;
    logic [pcrx_pkg::M_DATA_W-1:0]   r_m_data;
    logic [pcrx_pkg::M_USER_W-1:0]   r_m_user;

    // Decode of the offered event
    logic                            w_accept;
    logic                            w_in_range;
    logic                            w_ext;
    logic                            w_loc;
    logic [pcrx_pkg::PCR_W-1:0]      w_read;
    logic                            w_load;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_range      = (w_pcr_index < 8'(PCR_COUNT));
    assign w_ext           = w_in_range && (w_event_type != pcrx_pkg::NO_ACTION_TYPE);
    assign w_loc           = w_in_range && (w_pcr_index == 8'd0)
                             && (w_event_type == pcrx_pkg::NO_ACTION_TYPE)
                             && (w_body_size == pcrx_pkg::LOCALITY_BODY_SIZE)
                             && (w_sig_front == pcrx_pkg::SIG_FRONT)
                             && (w_sig_back == pcrx_pkg::SIG_BACK);
    // Out-of-range events read as zero
    assign w_read          = w_in_range ? r_pcr[w_pcr_index[IDX_W-1:0]] : '0;
    // Load the output register once it is free or being emptied this cycle
    assign w_load          = (r_state == S_DELIVER) && (!r_m_valid || i_m_axis_tready);

    // Shared round unit
    logic [W-1:0] w_f;
    logic [W-1:0] w_k;
    logic [W-1:0] w_temp;
    logic [W-1:0] w_sched_x;
    logic [W-1:0] w_sched;

    always_comb begin
        priority if (r_round < pcrx_pkg::RND_W'(20)) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = pcrx_pkg::K0;
        end else if (r_round < pcrx_pkg::RND_W'(40)) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = pcrx_pkg::K1;
        end else if (r_round < pcrx_pkg::RND_W'(60)) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = pcrx_pkg::K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = pcrx_pkg::K3;
        end
    end

    assign w_temp  = {r_a[W-6:0], r_a[W-1:W-5]} + w_f + r_e + w_k + r_w[0];
    // Next schedule word, sixteen rounds ahead of the one in use
    assign w_sched = {w_sched_x[W-2:0], w_sched_x[W-1]};

    assign w_sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    // Value of the PCR after the event
    logic [pcrx_pkg::PCR_W-1:0] w_new;

    always_comb begin
        priority if (r_ext) begin
            w_new = {pcrx_pkg::H0 + r_a, pcrx_pkg::H1 + r_b, pcrx_pkg::H2 + r_c,
                     pcrx_pkg::H3 + r_d, pcrx_pkg::H4 + r_e};
        end else if (r_loc) begin
            w_new = {r_old[pcrx_pkg::PCR_W-1:8], r_locb};
        end else begin
            w_new = r_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < PCR_COUNT; i++) begin
                r_pcr[i] <= '0;
            end
        end else begin
            // Raise on a new result, drop once the far side has taken the old one
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= w_pcr_index;
                        r_locb  <= w_locality;
                        r_ext   <= w_ext;
                        r_loc   <= w_loc;
                        r_valid <= w_in_range;
                        r_old   <= w_read;
                        r_round <= '0;
                        r_a     <= pcrx_pkg::H0;
                        r_b     <= pcrx_pkg::H1;
                        r_c     <= pcrx_pkg::H2;
                        r_d     <= pcrx_pkg::H3;
                        r_e     <= pcrx_pkg::H4;
                        // Single padded block: old PCR, digest, marker, length
                        r_w[0]  <= w_read[159:128];
                        r_w[1]  <= w_read[127:96];
                        r_w[2]  <= w_read[95:64];
                        r_w[3]  <= w_read[63:32];
                        r_w[4]  <= w_read[31:0];
                        r_w[5]  <= w_digest_top[63:32];
                        r_w[6]  <= w_digest_top[31:0];
                        r_w[7]  <= w_digest_middle[63:32];
                        r_w[8]  <= w_digest_middle[31:0];
                        r_w[9]  <= w_digest_tail;
                        r_w[10] <= pcrx_pkg::PAD_MARK;
                        r_w[11] <= '0;
                        r_w[12] <= '0;
                        r_w[13] <= '0;
                        r_w[14] <= '0;
                        r_w[15] <= pcrx_pkg::PAD_LEN;
                        r_state <= w_ext ? S_ROUND : S_FINISH;
                    end
                end
                S_ROUND: begin
                    r_e     <= r_d;
                    r_d     <= r_c;
                    r_c     <= {r_b[1:0], r_b[W-1:2]};
                    r_b     <= r_a;
                    r_a     <= w_temp;
                    for (int i = 0; i < pcrx_pkg::SCHED_LEN - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[pcrx_pkg::SCHED_LEN-1] <= w_sched;
                    r_round <= r_round + pcrx_pkg::RND_W'(1);
                    if (r_round == LastRound) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // Write back and hold the new value for delivery
                    if (r_valid) begin
                        r_pcr[r_idx[IDX_W-1:0]] <= w_new;
                    end
                    r_old   <= w_new;
                    r_state <= S_DELIVER;
                end
                S_DELIVER: begin
                    if (w_load) begin
                        r_m_data  <= {r_old[31:0], r_old[95:32], r_old[159:96], r_idx};
                        r_m_user  <= {r_valid, r_loc, r_ext};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // An extending event goes straight to the first round
    `PCRX_ASSERT_NEXT(a_ext_start, i_clk, i_rst_n, w_accept && w_ext,
        (r_state == S_ROUND) && (r_round == '0), "extension did not start at round zero")
    // The last round hands over to the write-back step
    `PCRX_ASSERT_NEXT(a_round_end, i_clk, i_rst_n,
        (r_state == S_ROUND) && (r_round == LastRound), r_state == S_FINISH,
        "round sequence overran")
    // Out-of-range results carry a zero value
    `PCRX_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser[pcrx_pkg::FLAG_VALID],
        o_m_axis_tdata[pcrx_pkg::M_DATA_W-1:8] == '0, "invalid index with nonzero value")
    // An event never both extends and sets the locality
    `PCRX_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, o_m_axis_tvalid,
        !(o_m_axis_tuser[pcrx_pkg::FLAG_EXTENDED] && o_m_axis_tuser[pcrx_pkg::FLAG_LOCALITY]),
        "extended and locality both set")

endmodule

`default_nettype wire
